// ===== design/patan2_pkg.sv =====
package patan2_pkg;

    localparam int IN_WIDTH_DEF   = 16;
    localparam int ANGLE_FRAC_DEF = 13;

    localparam int RATIO_BITS = 16;
    localparam int C_BITS     = RATIO_BITS + 1;
    localparam int SQ_W       = 2 * C_BITS;
    localparam int ANGLE_W    = 16;
    localparam int T_W        = 20;
    localparam int P_W        = T_W + C_BITS + 1;
    localparam int ROUND_HALF = 1 << (RATIO_BITS - 1);

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    localparam logic signed [T_W-1:0] COEF_P1 = T_W'(65522);
    localparam logic signed [T_W-1:0] COEF_P3 = T_W'(-21352);
    localparam logic signed [T_W-1:0] COEF_P5 = T_W'(10196);
    localparam logic signed [T_W-1:0] COEF_P7 = T_W'(-2905);

    typedef struct packed {
        logic zero;
        logic steep;
        logic neg_x;
        logic neg_y;
    } t_flags;

    // pi * 2^(frac + extra), rounded
    function automatic logic [63:0] pi_scaled(input int frac, input int extra);
        int sh;
        sh = 30 - frac - extra;
        return (PI_Q30 + (64'd1 << (sh - 1))) >> sh;
    endfunction

    // shift right by RATIO_BITS, half away from zero
    function automatic logic signed [T_W-1:0] rnd_q16(input logic signed [P_W-1:0] v);
        logic signed [P_W-1:0] s;
        s = v + (v[P_W-1] ? P_W'(ROUND_HALF - 1) : P_W'(ROUND_HALF));
        return T_W'(s >>> RATIO_BITS);
    endfunction

    function automatic logic signed [P_W-1:0] mul_tc(input logic signed [T_W-1:0] t,
                                                      input logic [C_BITS-1:0] c);
        logic signed [P_W-1:0] a;
        logic signed [P_W-1:0] b;
        a = P_W'(t);
        b = P_W'({1'b0, c});
        return a * b;
    endfunction

endpackage

// ===== design/patan2_in_if.sv =====
interface patan2_in_if #(
    parameter int IN_W = patan2_pkg::IN_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] vec_y;
    logic signed [IN_W-1:0] vec_x;

    modport source (output valid, output vec_y, output vec_x, input ready);
    modport sink   (input valid, input vec_y, input vec_x, output ready);
endinterface

// ===== design/patan2_out_if.sv =====
interface patan2_out_if;
    logic                           valid;
    logic                           ready;
    logic [patan2_pkg::ANGLE_W-1:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

// ===== design/patan2_div.sv =====
module patan2_div #(
    parameter int IN_W = patan2_pkg::IN_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [IN_W-1:0]          i_vec_y,
    input  logic signed [IN_W-1:0]          i_vec_x,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [patan2_pkg::C_BITS-1:0]   o_ratio,
    output patan2_pkg::t_flags              o_flags
);
    import patan2_pkg::*;

    localparam int NS = C_BITS;
    localparam int NW = IN_W + C_BITS;

    logic [IN_W-1:0]   r_rem [0:NS];
    logic [C_BITS-1:0] r_low [0:NS];
    logic [IN_W-1:0]   r_mx  [0:NS-1];
    t_flags            r_flg [0:NS];
    logic [NS:0]       r_v;
    logic [NS+1:0]     w_en;

    logic [IN_W-1:0] ay, ax, mn, mx;
    logic            steep;
    logic [NW-1:0]   num;

    always_comb begin
        ay    = i_vec_y[IN_W-1] ? (~i_vec_y + 1'b1) : i_vec_y;
        ax    = i_vec_x[IN_W-1] ? (~i_vec_x + 1'b1) : i_vec_x;
        steep = ay > ax;
        mn    = steep ? ax : ay;
        mx    = steep ? ay : ax;
        num   = NW'({mn, {RATIO_BITS{1'b0}}}) + NW'(mx >> 1);
    end

    always_comb begin
        w_en[NS+1] = i_ready;
        for (int k = NS; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k <= NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_rem[0]       <= num[NW-1:C_BITS];
            r_low[0]       <= num[C_BITS-1:0];
            r_mx[0]        <= mx;
            r_flg[0].zero  <= (ax == '0) && (ay == '0);
            r_flg[0].steep <= steep;
            r_flg[0].neg_x <= i_vec_x[IN_W-1];
            r_flg[0].neg_y <= i_vec_y[IN_W-1];
        end
    end

    // one restoring step per stage; quotient bits shift into the low word
    for (genvar k = 1; k <= NS; k++) begin : g_step
        logic [IN_W:0]     trial;
        logic [IN_W:0]     diff;
        logic              ge;
        logic [IN_W-1:0]   n_rem;
        logic [C_BITS-1:0] n_low;

        always_comb begin
            trial = {r_rem[k-1], r_low[k-1][C_BITS-1]};
            diff  = trial - {1'b0, r_mx[k-1]};
            ge    = trial >= {1'b0, r_mx[k-1]};
            n_rem = ge ? diff[IN_W-1:0] : trial[IN_W-1:0];
            n_low = {r_low[k-1][C_BITS-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                r_rem[k] <= n_rem;
                r_low[k] <= n_low;
                r_flg[k] <= r_flg[k-1];
            end
        end

        if (k < NS) begin : g_mx
            always_ff @(posedge i_clk) begin
                if (w_en[k]) begin
                    r_mx[k] <= r_mx[k-1];
                end
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[NS];
    assign o_ratio = r_low[NS];
    assign o_flags = r_flg[NS];

`ifndef SYNTH
    a_ratio_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS] && !r_flg[NS].zero |-> r_low[NS] <= C_BITS'(1 << RATIO_BITS))
        else $error("ratio above one");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS] && !i_ready |=> r_v[NS] && $stable(r_low[NS]) && $stable(r_flg[NS]))
        else $error("divider output changed while stalled");
`endif

endmodule

// ===== design/patan2_poly.sv =====
module patan2_poly (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [patan2_pkg::C_BITS-1:0]   i_ratio,
    input  patan2_pkg::t_flags              i_flags,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [patan2_pkg::C_BITS-1:0]   o_oct,
    output patan2_pkg::t_flags              o_flags
);
    import patan2_pkg::*;

    localparam int NST = 10;

    logic [NST-1:0]    r_v;
    logic [NST:0]      w_en;
    t_flags            r_flg [0:NST-1];
    logic [C_BITS-1:0] r_c   [0:7];
    logic [C_BITS-1:0] r_c2  [1:5];

    logic [SQ_W-1:0]          r_sq;
    logic signed [P_W-1:0]    r_p2, r_p4, r_p6, r_p8;
    logic signed [T_W-1:0]    r_t3, r_t5, r_t7;
    logic [C_BITS-1:0]        r_oct;

    logic [SQ_W-1:0]       n_ce;
    logic [SQ_W:0]         n_sq;
    logic signed [T_W-1:0] n_r8;

    always_comb begin
        n_ce = SQ_W'(i_ratio);
        n_sq = {1'b0, r_sq} + (SQ_W+1)'(ROUND_HALF);
        n_r8 = rnd_q16(r_p8);
    end

    always_comb begin
        w_en[NST] = i_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_sq     <= n_ce * n_ce;
            r_c[0]   <= i_ratio;
            r_flg[0] <= i_flags;
        end
        for (int k = 1; k < NST; k++) begin
            if (w_en[k]) begin
                r_flg[k] <= r_flg[k-1];
            end
        end
        for (int k = 1; k < 8; k++) begin
            if (w_en[k]) begin
                r_c[k] <= r_c[k-1];
            end
        end
        for (int k = 2; k < 6; k++) begin
            if (w_en[k]) begin
                r_c2[k] <= r_c2[k-1];
            end
        end
        if (w_en[1]) begin
            r_c2[1] <= n_sq[RATIO_BITS +: C_BITS];
        end
        if (w_en[2]) begin
            r_p2 <= mul_tc(COEF_P7, r_c2[1]);
        end
        if (w_en[3]) begin
            r_t3 <= rnd_q16(r_p2) + COEF_P5;
        end
        if (w_en[4]) begin
            r_p4 <= mul_tc(r_t3, r_c2[3]);
        end
        if (w_en[5]) begin
            r_t5 <= rnd_q16(r_p4) + COEF_P3;
        end
        if (w_en[6]) begin
            r_p6 <= mul_tc(r_t5, r_c2[5]);
        end
        if (w_en[7]) begin
            r_t7 <= rnd_q16(r_p6) + COEF_P1;
        end
        if (w_en[8]) begin
            r_p8 <= mul_tc(r_t7, r_c[7]);
        end
        if (w_en[9]) begin
            r_oct <= n_r8[T_W-1] ? '0 : n_r8[C_BITS-1:0];
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[NST-1];
    assign o_oct   = r_oct;
    assign o_flags = r_flg[NST-1];

endmodule

// ===== design/patan2_unfold.sv =====
module patan2_unfold #(
    parameter int ANGLE_F = patan2_pkg::ANGLE_FRAC_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [patan2_pkg::C_BITS-1:0]   i_oct,
    input  patan2_pkg::t_flags              i_flags,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [patan2_pkg::ANGLE_W-1:0]  o_angle
);
    import patan2_pkg::*;

    localparam int AW   = ANGLE_F + 4;
    localparam int CV_W = C_BITS + ANGLE_F + 1;

    localparam logic [AW-1:0] HALF_PI = AW'(pi_scaled(ANGLE_F, -1));
    localparam logic [AW-1:0] PI      = AW'(pi_scaled(ANGLE_F, 0));
    localparam logic [AW-1:0] TWO_PI  = AW'(pi_scaled(ANGLE_F, 1));

    logic [1:0]    r_v;
    logic [2:0]    w_en;
    logic [AW-1:0] r_a0;
    t_flags        r_flg0;
    logic [AW-1:0] r_ang;

    logic [CV_W-1:0] n_cv;
    logic [AW-1:0]   n_a0;
    logic [AW-1:0]   n_ax;
    logic [AW-1:0]   n_ang;

    always_comb begin
        n_cv = (CV_W'(i_oct) << ANGLE_F) + CV_W'(ROUND_HALF);
        n_a0 = AW'(n_cv >> RATIO_BITS);
        if (i_flags.steep) begin
            n_a0 = HALF_PI - n_a0;
        end
        n_ax  = r_flg0.neg_x ? (PI - r_a0) : r_a0;
        n_ang = r_flg0.neg_y ? (TWO_PI - n_ax) : n_ax;
        if (r_flg0.zero || n_ang >= TWO_PI) begin
            n_ang = '0;
        end
    end

    always_comb begin
        w_en[2] = i_ready;
        w_en[1] = !r_v[1] || w_en[2];
        w_en[0] = !r_v[0] || w_en[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            if (w_en[1]) begin
                r_v[1] <= r_v[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_a0   <= n_a0;
            r_flg0 <= i_flags;
        end
        if (w_en[1]) begin
            r_ang <= n_ang;
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[1];
    assign o_angle = ANGLE_W'(r_ang);

`ifndef SYNTH
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[1] |-> r_ang < TWO_PI)
        else $error("angle outside one turn");

    a_zero_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en[1] && r_v[0] && r_flg0.zero |=> r_v[1] && r_ang == '0)
        else $error("zero vector gave non-zero angle");
`endif

endmodule

// ===== design/polynomial_atan2_approximation_unit.sv =====
// Four-quadrant arctangent of (vec_y, vec_x), returned as an unsigned angle in [0, 2*pi)
// with ANGLE_FRAC_BITS fraction bits; a zero vector gives 0. Fully pipelined: one beat is
// taken every cycle while the output side keeps up, and each result passes in order through
// 1 magnitude/ordering stage, 17 restoring divider stages for the Q1.16 ratio,
// 10 stages for the squared ratio and the degree-7 Horner chain, and 2 unfold stages.
// A stall at the output only holds stages that carry a beat, so empty stages further up
// keep filling and the input stays ready while any stage is empty.
module polynomial_atan2_approximation_unit #(
    parameter int IN_WIDTH        = patan2_pkg::IN_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = patan2_pkg::ANGLE_FRAC_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    patan2_in_if.sink     i_vec,
    patan2_out_if.source  o_angle
);
    import patan2_pkg::*;

    logic              div_valid, div_ready;
    logic [C_BITS-1:0] div_ratio;
    t_flags            div_flags;

    logic              poly_valid, poly_ready;
    logic [C_BITS-1:0] poly_oct;
    t_flags            poly_flags;

    patan2_div #(
        .IN_W (IN_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_vec.valid),
        .o_ready (i_vec.ready),
        .i_vec_y (i_vec.vec_y),
        .i_vec_x (i_vec.vec_x),
        .o_valid (div_valid),
        .i_ready (div_ready),
        .o_ratio (div_ratio),
        .o_flags (div_flags)
    );

    patan2_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid),
        .o_ready (div_ready),
        .i_ratio (div_ratio),
        .i_flags (div_flags),
        .o_valid (poly_valid),
        .i_ready (poly_ready),
        .o_oct   (poly_oct),
        .o_flags (poly_flags)
    );

    patan2_unfold #(
        .ANGLE_F (ANGLE_FRAC_BITS)
    ) u_unfold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (poly_valid),
        .o_ready (poly_ready),
        .i_oct   (poly_oct),
        .i_flags (poly_flags),
        .o_valid (o_angle.valid),
        .i_ready (o_angle.ready),
        .o_angle (o_angle.angle)
    );

endmodule
